/* src/js_string_unescape_utf8_unit_macros.svh */
// Assertion macros shared by the string unescape unit.
`ifndef JS_STRING_UNESCAPE_UTF8_UNIT_MACROS_SVH
`define JS_STRING_UNESCAPE_UTF8_UNIT_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define JSU_CHECK_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jsu same-cycle check failed");

// Check a consequence in the cycle after its cause.
`define JSU_CHECK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jsu next-cycle check failed");

`endif

/* src/jsu_pkg.sv */
// Types, character codes and decode helpers of the string unescape unit.
package jsu_pkg;

   localparam int unsigned MAX_RES = 4;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_SEVEN = 8'h37;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_B  = 8'h62;
   localparam logic [7:0] CH_LO_F  = 8'h66;
   localparam logic [7:0] CH_LO_N  = 8'h6E;
   localparam logic [7:0] CH_LO_R  = 8'h72;
   localparam logic [7:0] CH_LO_T  = 8'h74;
   localparam logic [7:0] CH_LO_U  = 8'h75;
   localparam logic [7:0] CH_LO_V  = 8'h76;
   localparam logic [7:0] CH_LO_X  = 8'h78;
   localparam logic [7:0] CASE_BIT = 8'h20;

   localparam logic [7:0]  ZERO_CODE  = 8'h80;
   localparam logic [7:0]  CONT_MARK  = 8'h80;
   localparam logic [7:0]  LEAD2_MARK = 8'hC0;
   localparam logic [7:0]  LEAD3_MARK = 8'hE0;
   localparam logic [15:0] ONE_BYTE_MAX = 16'h007F;
   localparam logic [15:0] TWO_BYTE_MAX = 16'h07FF;
   localparam logic [15:0] OCT_CLAMP    = 16'd255;

   localparam logic [0:0] REG_QUOTE = 1'b0;
   localparam logic [7:0] QUOTE_RESET = 8'h22;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_CLOSE = 2'd1,
      KIND_END   = 2'd2,
      KIND_BREAK = 2'd3
   } kind_type;

   typedef enum logic [5:0] {
      MODE_NORMAL = 6'b000001,
      MODE_ESC    = 6'b000010,
      MODE_OCT    = 6'b000100,
      MODE_HEX2   = 6'b001000,
      MODE_HEX4   = 6'b010000,
      MODE_CRLF   = 6'b100000
   } mode_type;

   typedef struct packed {
      logic [7:0] data;
      kind_type   kind;
      logic       bad;
   } res_type;

   typedef struct packed {
      logic    emit;
      logic    esc;
      res_type res;
   } plain_type;

   typedef struct packed {
      logic [1:0]      cnt;
      logic [2:0][7:0] bytes;
   } utf8_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   function automatic res_type make_res(logic [7:0] data, kind_type kind, logic bad);
      res_type r;
      r.data = data;
      r.kind = kind;
      r.bad  = bad;
      return r;
   endfunction

   function automatic plain_type plain_fn(logic [7:0] b, logic [7:0] quote);
      plain_type p;
      p.emit = 1'b1;
      p.esc  = 1'b0;
      p.res  = make_res(b, KIND_DATA, 1'b0);
      if (b == quote) begin
         p.res = make_res(8'h00, KIND_CLOSE, 1'b0);
      end else if (b == CH_NUL) begin
         p.res = make_res(8'h00, KIND_END, 1'b0);
      end else if (b == CH_CR || b == CH_LF) begin
         p.res = make_res(8'h00, KIND_BREAK, 1'b0);
      end else if (b == CH_BSL) begin
         p.emit = 1'b0;
         p.esc  = 1'b1;
      end
      return p;
   endfunction

   function automatic hex_type hex_fn(logic [7:0] b);
      hex_type h;
      logic [7:0] lo;
      lo = b | CASE_BIT;
      h.ok  = 1'b0;
      h.val = 4'd0;
      if (b inside {[CH_ZERO:CH_NINE]}) begin
         h.ok  = 1'b1;
         h.val = b[3:0];
      end else if (lo inside {[CH_LO_A:CH_LO_F]}) begin
         h.ok  = 1'b1;
         h.val = 4'(lo - CH_LO_A + 8'd10);
      end
      return h;
   endfunction

   function automatic utf8_type utf8_fn(logic [15:0] v);
      utf8_type u;
      u.bytes = '0;
      if (v == 16'd0) begin
         u.cnt      = 2'd1;
         u.bytes[0] = ZERO_CODE;
      end else if (v <= ONE_BYTE_MAX) begin
         u.cnt      = 2'd1;
         u.bytes[0] = v[7:0];
      end else if (v <= TWO_BYTE_MAX) begin
         u.cnt      = 2'd2;
         u.bytes[0] = LEAD2_MARK | {3'd0, v[10:6]};
         u.bytes[1] = CONT_MARK | {2'd0, v[5:0]};
      end else begin
         u.cnt      = 2'd3;
         u.bytes[0] = LEAD3_MARK | {4'd0, v[15:12]};
         u.bytes[1] = CONT_MARK | {2'd0, v[11:6]};
         u.bytes[2] = CONT_MARK | {2'd0, v[5:0]};
      end
      return u;
   endfunction

   function automatic logic [15:0] oct_clamp(logic [15:0] v);
      return (v > OCT_CLAMP) ? OCT_CLAMP : v;
   endfunction

endpackage

/* src/js_string_unescape_utf8_unit.sv */
// Top level of the quoted-string unescape unit with UTF-8 output.
//
// Usage:
// - req channel: one raw string-body byte per word (req_in_byte), valid/ready.
// - rsp channel: decoded words, one per cycle while rsp_ready is high: rsp_out_byte, rsp_kind
//   (data, closed, input ended, line break), rsp_bad_escape, and rsp_last on
//   the final word caused by a request byte.
// - csr port: APB-style; register 0 at address 0 is the closing quote byte.
// Timing: words of a byte appear on rsp in the cycle after it is accepted.
// Throughput: one byte per cycle when it decodes to at most one word and
// rsp_ready is high; a byte that yields n words (up to four) holds the
// result buffer until its last word drains, since the buffer drains one word
// per cycle while rsp_ready is high. A byte that yields nothing leaves it empty.
// Reset: decoder returns to plain text, result buffer empties, the quote
// byte returns to a double quote.
// Stall: while rsp_ready is low the buffered words hold and req_ready drops
// once the buffer cannot be freed in the current cycle.
`include "js_string_unescape_utf8_unit_macros.svh"

module js_string_unescape_utf8_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic [1:0]  rsp_kind,
   output logic        rsp_bad_escape,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import jsu_pkg::*;

   logic [7:0]  quote_ff;
   mode_type    mode_ff, mode_in;
   logic [15:0] ev_ff, ev_in;
   logic [2:0]  dc_ff, dc_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [1:0]  pos_ff, pos_in;
   res_type     ent_ff [MAX_RES];
   res_type     ent_in [MAX_RES];

   logic        acc;
   logic        csr_wr;
   logic [0:0]  csr_idx;
   logic        code_go;
   logic [15:0] code_v;
   logic [1:0]  ntail;
   res_type     tail [2];
   plain_type   pl;
   utf8_type    enc;
   hex_type     hx;
   logic [2:0]  ncode;
   logic [2:0]  nres;
   logic [2:0]  dc_inc;
   logic [15:0] ev_oct;
   logic [15:0] ev_hex;
   logic [2:0]  limit;
   logic        use_plain;
   logic [2:0]  slot;
   res_type     cur;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[2:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_idx == REG_QUOTE) ? {24'd0, quote_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         quote_ff <= QUOTE_RESET;
      end else if (csr_wr && csr_idx == REG_QUOTE) begin
         quote_ff <= csr_pwdata[7:0];
      end
   end

   // handshake
   assign rsp_valid = (cnt_ff != 3'd0);
   assign req_ready = (cnt_ff == 3'd0) || (rsp_ready && cnt_ff == 3'd1);
   assign acc       = req_valid && req_ready;

   assign cur            = ent_ff[pos_ff];
   assign rsp_out_byte   = cur.data;
   assign rsp_kind       = cur.kind;
   assign rsp_bad_escape = cur.bad;
   assign rsp_last       = (cnt_ff == 3'd1);

   // decode
   always_comb begin
      mode_in   = mode_ff;
      ev_in     = ev_ff;
      dc_in     = dc_ff;
      code_go   = 1'b0;
      code_v    = ev_ff;
      ntail     = 2'd0;
      tail[0]   = '0;
      tail[1]   = '0;
      use_plain = 1'b0;
      pl        = plain_fn(req_in_byte, quote_ff);
      hx        = hex_fn(req_in_byte);
      dc_inc    = dc_ff + 3'd1;
      ev_oct    = {ev_ff[12:0], req_in_byte[2:0]};
      ev_hex    = {ev_ff[11:0], hx.val};
      limit     = (mode_ff == MODE_HEX2) ? 3'd2 : 3'd4;

      case (mode_ff)
         MODE_ESC: begin
            mode_in = MODE_NORMAL;
            if (req_in_byte inside {[CH_ZERO:CH_SEVEN]}) begin
               mode_in = MODE_OCT;
               ev_in   = {13'd0, req_in_byte[2:0]};
               dc_in   = 3'd1;
            end else begin
               ntail = 2'd1;
               case (req_in_byte)
                  CH_NUL:   tail[0] = make_res(8'h00, KIND_END, 1'b0);
                  CH_CR: begin
                     ntail   = 2'd0;
                     mode_in = MODE_CRLF;
                  end
                  CH_LF:    ntail = 2'd0;
                  CH_LO_N:  tail[0] = make_res(CH_LF, KIND_DATA, 1'b0);
                  CH_LO_R:  tail[0] = make_res(CH_CR, KIND_DATA, 1'b0);
                  CH_LO_T:  tail[0] = make_res(CH_TAB, KIND_DATA, 1'b0);
                  CH_LO_B:  tail[0] = make_res(CH_BS, KIND_DATA, 1'b0);
                  CH_LO_F:  tail[0] = make_res(CH_FF, KIND_DATA, 1'b0);
                  CH_LO_V:  tail[0] = make_res(CH_VT, KIND_DATA, 1'b0);
                  CH_SLASH: begin
                     ntail   = 2'd2;
                     tail[0] = make_res(CH_BSL, KIND_DATA, 1'b0);
                     tail[1] = make_res(CH_SLASH, KIND_DATA, 1'b0);
                  end
                  CH_LO_U: begin
                     ntail   = 2'd0;
                     mode_in = MODE_HEX4;
                     ev_in   = 16'd0;
                     dc_in   = 3'd0;
                  end
                  CH_LO_X: begin
                     ntail   = 2'd0;
                     mode_in = MODE_HEX2;
                     ev_in   = 16'd0;
                     dc_in   = 3'd0;
                  end
                  CH_DQUOTE, CH_SQUOTE, CH_BSL: begin
                     tail[0] = make_res(req_in_byte, KIND_DATA, 1'b0);
                  end
                  default:  tail[0] = make_res(req_in_byte, KIND_DATA, 1'b1);
               endcase
            end
         end
         MODE_OCT: begin
            if (req_in_byte != quote_ff && req_in_byte inside {[CH_ZERO:CH_SEVEN]}) begin
               ev_in = ev_oct;
               dc_in = dc_inc;
               if (dc_inc >= 3'd3) begin
                  code_go = 1'b1;
                  code_v  = oct_clamp(ev_oct);
                  mode_in = MODE_NORMAL;
               end
            end else begin
               code_go   = 1'b1;
               code_v    = oct_clamp(ev_ff);
               use_plain = 1'b1;
            end
         end
         MODE_HEX2, MODE_HEX4: begin
            if (req_in_byte != quote_ff && hx.ok) begin
               ev_in = ev_hex;
               dc_in = dc_inc;
               if (dc_inc >= limit) begin
                  code_go = 1'b1;
                  code_v  = ev_hex;
                  mode_in = MODE_NORMAL;
               end
            end else begin
               code_go   = 1'b1;
               code_v    = ev_ff;
               use_plain = 1'b1;
            end
         end
         MODE_CRLF: begin
            mode_in   = MODE_NORMAL;
            use_plain = (req_in_byte != CH_LF);
         end
         default: begin
            use_plain = 1'b1;
         end
      endcase

      if (use_plain) begin
         mode_in = pl.esc ? MODE_ESC : MODE_NORMAL;
         if (pl.emit) begin
            ntail   = 2'd1;
            tail[0] = pl.res;
         end
      end
   end

   // pack code bytes then tail words into the result slots
   always_comb begin
      enc   = utf8_fn(code_v);
      ncode = code_go ? {1'b0, enc.cnt} : 3'd0;
      nres  = ncode + {1'b0, ntail};
      for (int i = 0; i < MAX_RES; i++) begin
         slot = 3'(i) - ncode;
         if (3'(i) < ncode) begin
            ent_in[i] = make_res(enc.bytes[i[1:0]], KIND_DATA, 1'b0);
         end else if (slot < {1'b0, ntail}) begin
            ent_in[i] = tail[slot[0]];
         end else begin
            ent_in[i] = '0;
         end
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      pos_in = pos_ff;
      if (acc) begin
         cnt_in = nres;
         pos_in = 2'd0;
      end else if (rsp_valid && rsp_ready) begin
         cnt_in = cnt_ff - 3'd1;
         pos_in = pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         ev_ff   <= 16'd0;
         dc_ff   <= 3'd0;
         cnt_ff  <= 3'd0;
         pos_ff  <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         pos_ff <= pos_in;
         if (acc) begin
            mode_ff <= mode_in;
            ev_ff   <= ev_in;
            dc_ff   <= dc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         for (int i = 0; i < MAX_RES; i++) begin
            ent_ff[i] <= ent_in[i];
         end
      end
   end

   `JSU_CHECK_NOW(a_busy_blocks_req, clock, reset, cnt_ff > 3'd1, !req_ready)
   `JSU_CHECK_NEXT(a_words_follow_accept, clock, reset, acc && nres != 3'd0, rsp_valid)
   `JSU_CHECK_NEXT(a_quote_closes, clock, reset,
      acc && mode_ff == MODE_NORMAL && req_in_byte == quote_ff,
      rsp_valid && rsp_kind == KIND_CLOSE && rsp_last && mode_ff == MODE_NORMAL)

endmodule
